// ===== rtl/bgi_pkg.sv =====
// Package for the bicubic grid interpolator: payload structs, grid constants,
// and controller-to-datapath command/status types. No dependencies.
package bgi_pkg;

  localparam int GridSize = 64;
  localparam int IdxW = $clog2(GridSize);
  localparam int AddrW = 2 * IdxW;
  localparam int AccW = 48;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef struct packed {
    logic cmd;
    logic [5:0] grid_row;
    logic [5:0] grid_col;
    logic signed [31:0] sample_value;
    logic [3:0] sub_row;
    logic [3:0] sub_col;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] interp_value;
    logic saturated;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic write_grid;
    logic div_start;
    logic read_req;
    logic [1:0] read_x;
    logic [1:0] read_y;
    logic [2:0] cubic_sel;
    logic cubic_start;
    logic second_pass;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic cubic_done;
  } dp_stat_t;

  // Mirror a neighbor index past either grid edge.
  function automatic logic [IdxW-1:0] mirror(input logic signed [IdxW+1:0] i);
    logic signed [IdxW+1:0] r;
    begin
      if (i < 0) begin
        r = -i;
      end else if (i >= GridSize) begin
        r = (IdxW+2)'(2 * (GridSize - 1)) - i;
      end else begin
        r = i;
      end
      mirror = r[IdxW-1:0];
    end
  endfunction

endpackage

// ===== rtl/bicubic_grid_interpolator.sv =====
// Top level of the bicubic grid interpolator: ties the controller to the
// datapath and holds the factor register. Uses bgi_pkg, bgi_ctrl, bgi_datapath.
//
//   channel   signals                     direction
//   request   in_valid/in_ready/in_data   in
//   result    out_valid/out_ready/out_data out
//   config    cfg_we/cfg_data             in
//
// A load is written at the edge that accepts it, so loads can follow back to back.
// A query goes through the fraction divider (two divides and a handoff), sixteen
// grid reads on the one read port, five cubic evaluations on one multiplier, and a
// finish step that loads the result register; the block then returns to idle and
// takes the next request. Reset is synchronous; grid contents are not cleared.
// A waiting result holds the block until taken.
module bicubic_grid_interpolator (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  bgi_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output bgi_pkg::out_item_t out_data,
  input  logic cfg_we,
  input  logic [4:0] cfg_data
);

  logic [4:0] factor;
  bgi_pkg::dp_cmd_t cmd;
  bgi_pkg::dp_stat_t stat;
  logic out_busy;

  always_ff @(posedge clk) begin
    if (rst) factor <= 5'd4;
    else if (cfg_we) factor <= cfg_data;
  end

  bgi_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_data.cmd), .out_busy(out_busy), .cmd(cmd), .stat(stat)
  );

  bgi_datapath u_dp (
    .clk(clk), .rst(rst), .factor(factor), .in_item(in_data), .cmd(cmd),
    .stat(stat), .out_busy(out_busy), .out_valid_q(out_valid),
    .out_ready(out_ready), .out_item(out_data)
  );

endmodule

// ===== rtl/bgi_ctrl.sv =====
// Controller for the bicubic grid interpolator: sequences loads, fraction
// divide, sixteen grid reads and five cubic evaluations. Uses bgi_pkg.
module bgi_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_cmd,
  input  logic out_busy,
  output bgi_pkg::dp_cmd_t cmd,
  input  bgi_pkg::dp_stat_t stat
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv = 3'd1;
  localparam logic [2:0] StRead = 3'd2;
  localparam logic [2:0] StCubic = 3'd3;
  localparam logic [2:0] StFinal = 3'd4;
  localparam logic [2:0] StOut = 3'd5;

  logic [2:0] state, state_next;
  logic [3:0] rd, rd_next;
  logic [2:0] cub, cub_next;
  logic cstart, cstart_next;

  assign in_ready = (state == StIdle);

  always_comb begin
    state_next = state;
    rd_next = rd;
    cub_next = cub;
    cstart_next = 1'b0;
    cmd = '0;
    cmd.read_x = rd[3:2];
    cmd.read_y = rd[1:0];
    cmd.cubic_sel = cub;
    cmd.cubic_start = cstart;
    cmd.second_pass = (cub == 3'd4);
    unique case (state)
      StIdle: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_cmd == bgi_pkg::CmdLoad) begin
            cmd.write_grid = 1'b1;
          end else begin
            cmd.div_start = 1'b1;
            state_next = StDiv;
          end
        end
      end
      StDiv: begin
        if (stat.div_done) begin
          state_next = StRead;
          rd_next = '0;
        end
      end
      StRead: begin
        // one read a cycle; the read data is registered, then stored in its point slot
        cmd.read_req = 1'b1;
        rd_next = rd + 4'd1;
        if (rd == 4'd15) begin
          state_next = StCubic;
          cub_next = '0;
          cstart_next = 1'b1;
        end
      end
      StCubic: begin
        if (stat.cubic_done) begin
          cub_next = cub + 3'd1;
          cstart_next = 1'b1;
          if (cub == 3'd4) begin
            cstart_next = 1'b0;
            state_next = StFinal;
          end
        end
      end
      StFinal: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_next = StIdle;
        end
      end
      StOut: state_next = StIdle;
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      rd <= '0;
      cub <= '0;
      cstart <= 1'b0;
    end else begin
      state <= state_next;
      rd <= rd_next;
      cub <= cub_next;
      cstart <= cstart_next;
    end
  end

endmodule

// ===== rtl/bgi_datapath.sv =====
// Datapath for the bicubic grid interpolator: grid memory, fraction divider,
// sequential cubic unit and output register. Uses bgi_pkg.
module bgi_datapath (
  input  logic clk,
  input  logic rst,
  input  logic [4:0] factor,
  input  bgi_pkg::in_item_t in_item,
  input  bgi_pkg::dp_cmd_t cmd,
  output bgi_pkg::dp_stat_t stat,
  output logic out_busy,
  output logic out_valid_q,
  input  logic out_ready,
  output bgi_pkg::out_item_t out_item
);

  localparam int IW = bgi_pkg::IdxW;
  localparam int AW = bgi_pkg::AccW;

  logic signed [31:0] mem [bgi_pkg::GridSize*bgi_pkg::GridSize];
  logic signed [31:0] rdata;
  logic rvalid;
  logic [3:0] rslot;
  logic signed [31:0] pts [16];
  logic signed [AW-1:0] across [4];

  logic [IW-1:0] row, col;
  logic [3:0] sr, sc;
  logic [4:0] f;
  logic signed [31:0] negv;
  logic [IW-1:0] wr_row, wr_col;
  logic wr_ok;
  logic div_done, cubic_done;

  assign stat = {div_done, cubic_done};

  // Negate on load; most negative saturates.
  always_comb begin
    negv = (in_item.sample_value == 32'sh8000_0000) ? 32'sh7fff_ffff
                                                   : -in_item.sample_value;
    wr_ok = ({2'b0, in_item.grid_row} < 8'(bgi_pkg::GridSize))
         && ({2'b0, in_item.grid_col} < 8'(bgi_pkg::GridSize));
    wr_row = in_item.grid_row[IW-1:0];
    wr_col = in_item.grid_col[IW-1:0];
    f = (factor == 5'd0) ? 5'd1 : factor;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row <= ({2'b0, in_item.grid_row} > 8'(bgi_pkg::GridSize - 1))
           ? IW'(bgi_pkg::GridSize - 1) : in_item.grid_row[IW-1:0];
      col <= ({2'b0, in_item.grid_col} > 8'(bgi_pkg::GridSize - 1))
           ? IW'(bgi_pkg::GridSize - 1) : in_item.grid_col[IW-1:0];
      sr <= in_item.sub_row;
      sc <= in_item.sub_col;
    end
  end

  // Memory: one write port, one registered read port.
  logic [bgi_pkg::AddrW-1:0] raddr;
  logic signed [IW+1:0] ri, ci;
  always_comb begin
    ri = $signed({2'b0, row}) + $signed((IW+2)'(cmd.read_x)) - (IW+2)'(1);
    ci = $signed({2'b0, col}) + $signed((IW+2)'(cmd.read_y)) - (IW+2)'(1);
    raddr = {bgi_pkg::mirror(ri), bgi_pkg::mirror(ci)};
  end

  always_ff @(posedge clk) begin
    if (cmd.write_grid && wr_ok) mem[{wr_row, wr_col}] <= negv;
    if (cmd.read_req) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) rvalid <= 1'b0;
    else rvalid <= cmd.read_req;
    rslot <= {cmd.read_x, cmd.read_y};
    if (rvalid) pts[rslot] <= rdata;
  end

  // Restoring divider for (sub << 16) / f, one quotient bit a cycle.
  logic [20:0] dividend;
  logic [4:0] rem;
  logic [4:0] dcnt;
  logic dbusy, dsel;
  logic [16:0] qr, qc;
  logic [3:0] sclamp;
  logic [5:0] trial;
  always_comb begin
    if (!dsel) begin
      sclamp = ({1'b0, sr} > f - 5'd1) ? 4'(f - 5'd1) : sr;
      if (row == IW'(bgi_pkg::GridSize - 1)) sclamp = '0;
    end else begin
      sclamp = ({1'b0, sc} > f - 5'd1) ? 4'(f - 5'd1) : sc;
      if (col == IW'(bgi_pkg::GridSize - 1)) sclamp = '0;
    end
    trial = {rem, dividend[20]} - {1'b0, f};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      dsel <= 1'b0;
      div_done <= 1'b0;
    end else begin
      div_done <= 1'b0;
      if (cmd.div_start) begin
        dbusy <= 1'b1;
        dsel <= 1'b0;
        dcnt <= '0;
        rem <= '0;
        dividend <= '0;
      end else if (dbusy) begin
        if (dcnt == 5'd0) begin
          dividend <= {1'b0, sclamp, 16'd0};
          dcnt <= 5'd1;
        end else begin
          if (!trial[5]) begin
            rem <= trial[4:0];
          end else begin
            rem <= {rem[3:0], dividend[20]};
          end
          dividend <= {dividend[19:0], ~trial[5]};
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd21) begin
            if (!dsel) begin
              qr <= {dividend[15:0], ~trial[5]};
              dsel <= 1'b1;
              dcnt <= '0;
              rem <= '0;
            end else begin
              qc <= {dividend[15:0], ~trial[5]};
              dbusy <= 1'b0;
              div_done <= 1'b1;
            end
          end
        end
      end
    end
  end

  // Cubic unit: at most one multiply per step.
  logic signed [AW-1:0] p0, p1, p2, p3, ca, cb, cc, h;
  logic signed [17:0] t;
  logic signed [AW+17:0] prod;
  logic [2:0] step;
  logic cbusy;

  function automatic logic signed [AW-1:0] rshift(input logic signed [AW+17:0] v,
                                                   input logic s17);
    logic signed [AW+17:0] r;
    begin
      if (s17) r = (v + (AW+18)'(65536)) >>> 17;
      else r = (v + (AW+18)'(32768)) >>> 16;
      rshift = r[AW-1:0];
    end
  endfunction

  always_comb begin
    if (cmd.second_pass) begin
      p0 = across[0]; p1 = across[1]; p2 = across[2]; p3 = across[3];
      t = $signed({1'b0, qr});
    end else begin
      p0 = AW'(pts[{cmd.cubic_sel[1:0], 2'd0}]);
      p1 = AW'(pts[{cmd.cubic_sel[1:0], 2'd1}]);
      p2 = AW'(pts[{cmd.cubic_sel[1:0], 2'd2}]);
      p3 = AW'(pts[{cmd.cubic_sel[1:0], 2'd3}]);
      t = $signed({1'b0, qc});
    end
    prod = h * t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cbusy <= 1'b0;
      cubic_done <= 1'b0;
    end else begin
      cubic_done <= 1'b0;
      if (cmd.cubic_start) begin
        cbusy <= 1'b1;
        step <= '0;
        ca <= p3 - 3 * p2 + 3 * p1 - p0;
        cb <= -p3 + 4 * p2 - 5 * p1 + 2 * p0;
        cc <= p2 - p0;
      end else if (cbusy) begin
        step <= step + 3'd1;
        case (step)
          3'd0: h <= ca;
          3'd1: h <= rshift(prod, 1'b0) + cb;
          3'd2: h <= rshift(prod, 1'b0) + cc;
          default: begin
            if (cmd.second_pass) h <= p1 + rshift(prod, 1'b1);
            else across[cmd.cubic_sel[1:0]] <= p1 + rshift(prod, 1'b1);
            cbusy <= 1'b0;
            cubic_done <= 1'b1;
          end
        endcase
      end
    end
  end

  // Output register with saturation.
  assign out_busy = out_valid_q && !out_ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready) out_valid_q <= 1'b0;
      if (cmd.finish) begin
        out_valid_q <= 1'b1;
        if (h > AW'(64'sh7fff_ffff)) begin
          out_item.interp_value <= 32'sh7fff_ffff;
          out_item.saturated <= 1'b1;
        end else if (h < -AW'(64'sh8000_0000)) begin
          out_item.interp_value <= 32'sh8000_0000;
          out_item.saturated <= 1'b1;
        end else begin
          out_item.interp_value <= h[31:0];
          out_item.saturated <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== test/bgi_checker.sv =====
`timescale 1ns / 100ps
// Checker for the bicubic grid interpolator: watches the request, result and
// config channels, predicts each query result and compares it. Uses bgi_pkg.
module bgi_checker (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  bgi_pkg::in_item_t in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  bgi_pkg::out_item_t out_data,
  input  logic cfg_we,
  input  logic [4:0] cfg_data,
  output int error_count,
  output int pending_count
);

  localparam int Last = bgi_pkg::GridSize - 1;

  logic signed [31:0] grid_mem [bgi_pkg::GridSize*bgi_pkg::GridSize];
  logic [4:0] factor;
  bgi_pkg::out_item_t expected_q [$];

  function automatic longint round_shr(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint catmull_rom(longint p0, longint p1, longint p2, longint p3,
                                         longint t);
    longint a, b, c, h;
    a = p3 - 3 * p2 + 3 * p1 - p0;
    b = -p3 + 4 * p2 - 5 * p1 + 2 * p0;
    c = p2 - p0;
    h = round_shr(a * t, 16) + b;
    h = round_shr(h * t, 16) + c;
    return p1 + round_shr(h * t, 17);
  endfunction

  function automatic int reflect(int i);
    if (i < 0) return -i;
    if (i >= bgi_pkg::GridSize) return 2 * Last - i;
    return i;
  endfunction

  function automatic longint frac_of(int sub, bit last_cell);
    int f;
    f = (factor == 0) ? 1 : int'(factor);
    if (sub > f - 1) sub = f - 1;
    if (last_cell) sub = 0;
    return (longint'(sub) <<< 16) / f;
  endfunction

  function automatic bgi_pkg::out_item_t interpolate(bgi_pkg::in_item_t q);
    longint tr, tc, res;
    longint row_val [4];
    int r, c0, c1, c2, c3;
    bgi_pkg::out_item_t o;
    tr = frac_of(int'(q.sub_row), q.grid_row == Last);
    tc = frac_of(int'(q.sub_col), q.grid_col == Last);
    c0 = reflect(int'(q.grid_col) - 1);
    c1 = reflect(int'(q.grid_col));
    c2 = reflect(int'(q.grid_col) + 1);
    c3 = reflect(int'(q.grid_col) + 2);
    for (int x = 0; x < 4; x++) begin
      r = reflect(int'(q.grid_row) + x - 1) * bgi_pkg::GridSize;
      row_val[x] = catmull_rom(grid_mem[r+c0], grid_mem[r+c1], grid_mem[r+c2],
                               grid_mem[r+c3], tc);
    end
    res = catmull_rom(row_val[0], row_val[1], row_val[2], row_val[3], tr);
    o.saturated = 1'b1;
    if (res > 64'sh7FFFFFFF) res = 64'sh7FFFFFFF;
    else if (res < -64'sh80000000) res = -64'sh80000000;
    else o.saturated = 1'b0;
    o.interp_value = res[31:0];
    return o;
  endfunction

  assign pending_count = expected_q.size();

  always @(posedge clk) begin
    bgi_pkg::out_item_t exp_item;
    if (rst) begin
      factor <= 5'd4;
      expected_q.delete();
      error_count <= 0;
    end else begin
      if (cfg_we) factor <= cfg_data;
      if (in_valid && in_ready) begin
        if (in_data.cmd == bgi_pkg::CmdLoad) begin
          grid_mem[int'(in_data.grid_row) * bgi_pkg::GridSize + int'(in_data.grid_col)] <=
              (in_data.sample_value == 32'sh80000000) ? 32'sh7FFFFFFF
                                                      : -in_data.sample_value;
        end else begin
          expected_q.push_back(interpolate(in_data));
        end
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          error_count <= error_count + 1;
          if (error_count < 10) $display("unexpected result %h", out_data);
        end else begin
          exp_item = expected_q.pop_front();
          if (out_data.interp_value !== exp_item.interp_value ||
              out_data.saturated !== exp_item.saturated) begin
            error_count <= error_count + 1;
            if (error_count < 10)
              $display("mismatch: expected value %h sat %b, got value %h sat %b",
                       exp_item.interp_value, exp_item.saturated,
                       out_data.interp_value, out_data.saturated);
          end
        end
      end
    end
  end
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Top of the interpolator testbench: clock, reset, request and config
// stimulus, result back-pressure and verdict. Uses bgi_pkg and bgi_checker.
module testbench;

  localparam int IdleLimit = 5000;
  localparam int QueryLatency = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  bgi_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bgi_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [4:0] cfg_data = 5'd4;
  int error_count, pending_count;
  int burst_left = 0;
  int idle_cycles = 0;
  bit hold_req = 1'b0;

  always #5 clk = ~clk;

  bicubic_grid_interpolator i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  bgi_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .error_count(error_count), .pending_count(pending_count)
  );

  // Receiver stall pattern; a long hold-off on request from the stimulus.
  always @(negedge clk) begin
    int hold_left;
    if (hold_req) begin
      hold_req = 1'b0;
      out_ready <= 1'b0;
      for (hold_left = 400; hold_left > 0; hold_left--) @(negedge clk);
    end else begin
      case ($urandom_range(0, 3))
        0: out_ready <= ($urandom_range(0, 3) == 0);
        1: out_ready <= 1'b1;
        default: out_ready <= $urandom_range(0, 1);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("bicubic_grid_interpolator regression: fail");
      $finish;
    end
  end

  task automatic send(bgi_pkg::in_item_t it);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 90) : $urandom_range(0, 4);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return 32'h0;
      3: return {{16{1'b0}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [5:0] pick_index();
    case ($urandom_range(0, 5))
      0: return 6'd0;
      1: return 6'd63;
      2: return 6'($urandom_range(1, 2));
      3: return 6'($urandom_range(61, 62));
      default: return 6'($urandom);
    endcase
  endfunction

  // Query cells whose neighborhoods lie inside the filled bands.
  function automatic logic [5:0] pick_cell();
    case ($urandom_range(0, 2))
      0: return 6'($urandom_range(0, 3));
      1: return 6'($urandom_range(31, 33));
      default: return 6'($urandom_range(60, 63));
    endcase
  endfunction

  function automatic bit in_band(int i);
    return (i <= 5) || (i >= 30 && i <= 35) || (i >= 58);
  endfunction

  function automatic bgi_pkg::in_item_t make_item(logic cmd, logic [5:0] row,
                                                  logic [5:0] col, logic [31:0] value,
                                                  logic [3:0] sr, logic [3:0] sc);
    bgi_pkg::in_item_t it;
    it.cmd = cmd;
    it.grid_row = row;
    it.grid_col = col;
    it.sample_value = value;
    it.sub_row = sr;
    it.sub_col = sc;
    return it;
  endfunction

  function automatic bgi_pkg::in_item_t random_item();
    logic cmd;
    cmd = ($urandom_range(0, 9) < 4) ? bgi_pkg::CmdQuery : bgi_pkg::CmdLoad;
    if (cmd == bgi_pkg::CmdQuery)
      return make_item(cmd, pick_cell(), pick_cell(), pick_sample(),
                       4'($urandom), 4'($urandom));
    return make_item(cmd, pick_index(), pick_index(), pick_sample(),
                     4'($urandom), 4'($urandom));
  endfunction

  // Write the factor only once every query result has drained.
  task automatic set_factor(logic [4:0] f);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (QueryLatency) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= f;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [4:0] phase_factor [6] = '{5'd1, 5'd16, 5'd7, 5'd0, 5'd31, 5'd4};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fill the edge and middle bands so no query reads an unwritten entry.
    for (int r = 0; r < bgi_pkg::GridSize; r++)
      for (int c = 0; c < bgi_pkg::GridSize; c++)
        if (in_band(r) && in_band(c))
          send(make_item(bgi_pkg::CmdLoad, 6'(r), 6'(c), pick_sample(),
                         4'($urandom), 4'($urandom)));

    // Directed: sample extremes, corners, clamped sub-positions, overshoot.
    send(make_item(bgi_pkg::CmdLoad, 6'd0, 6'd0, 32'h80000000, 4'd0, 4'd0));
    send(make_item(bgi_pkg::CmdLoad, 6'd0, 6'd1, 32'h7FFFFFFF, 4'd15, 4'd15));
    send(make_item(bgi_pkg::CmdQuery, 6'd0, 6'd0, 32'h0, 4'd0, 4'd0));
    send(make_item(bgi_pkg::CmdQuery, 6'd0, 6'd0, 32'hFFFFFFFF, 4'd15, 4'd15));
    send(make_item(bgi_pkg::CmdQuery, 6'd63, 6'd63, 32'h0, 4'd3, 4'd3));
    send(make_item(bgi_pkg::CmdQuery, 6'd0, 6'd63, 32'h0, 4'd1, 4'd2));
    send(make_item(bgi_pkg::CmdQuery, 6'd63, 6'd0, 32'h0, 4'd2, 4'd1));
    for (int r = 9; r <= 12; r++)
      for (int c = 9; c <= 12; c++)
        send(make_item(bgi_pkg::CmdLoad, 6'(r), 6'(c),
                       ((r + c) % 2) ? 32'h80000000 : 32'h7FFFFFFF, 4'd0, 4'd0));
    send(make_item(bgi_pkg::CmdQuery, 6'd10, 6'd10, 32'h0, 4'd2, 4'd2));
    send(make_item(bgi_pkg::CmdQuery, 6'd10, 6'd10, 32'h0, 4'd1, 4'd3));
    set_factor(5'd4);

    for (int p = 0; p < 6; p++) begin
      set_factor(phase_factor[p]);
      for (int n = 0; n < 235; n++) begin
        if (p == 2 && n == 100) hold_req = 1'b1;
        send(random_item());
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (QueryLatency) @(posedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("bicubic_grid_interpolator regression: pass");
    end else begin
      $display("bicubic_grid_interpolator regression: fail");
    end
    $finish;
  end
endmodule
